### rtl/core/jqs_pkg.sv
package jqs_pkg;

   // One table entry as it is held in the job memory.
   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  priority_level;
      logic [15:0] left;
   } jqs_entry_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_HEAD_RD,
      ST_DONE
   } jqs_state_type;

   // Which logical table position the memory read port looks at.
   typedef enum logic [1:0] {
      RD_HEAD,
      RD_CURSOR,
      RD_CURSOR_M1
   } jqs_rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load_req;
      logic           cursor_clr;
      logic           cursor_inc;
      logic           cursor_dec;
      logic           cursor_to_count;
      logic           pos_from_cursor;
      jqs_rd_sel_type rd_sel;
      logic           shift_wr;
      logic           insert;
      logic           tick_update;
      logic           load_rsp;
   } jqs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_func;
      logic full;
      logic empty;
      logic mode;
      logic cursor_at_count;
      logic match;
      logic cursor_next_is_pos;
   } jqs_status_type;

endpackage

### rtl/core/job_queue_scheduler_core.sv
// A FIFO add writes the new job at the tail. A priority add first scans the table
// for its insertion point and then moves the jobs from that point on one place
// toward the tail; the scan and the shift share one read port. A refused add and a
// tick on an empty table only read the head back. One request is worked at a time:
// a new one is taken once the last result is loaded into the result register.
// Reset (synchronous, active high) empties the table and selects arrival order.
module job_queue_scheduler_core
   import jqs_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_job_id,
   input  logic [15:0] req_job_duration,
   input  logic [7:0]  req_job_priority,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_running_valid,
   output logic [7:0]  rsp_running_id,
   output logic [15:0] rsp_running_left,
   output logic        rsp_finished,
   output logic [7:0]  rsp_finished_id,
   output logic [4:0]  rsp_job_count
);

   jqs_cmd_type    cmd;
   jqs_status_type status;

   // Sequencer for add and tick requests.
   jqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Job table, pointers and result register.
   jqs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_func          (req_func),
      .req_job_id        (req_job_id),
      .req_job_duration  (req_job_duration),
      .req_job_priority  (req_job_priority),
      .rsp_accepted      (rsp_accepted),
      .rsp_running_valid (rsp_running_valid),
      .rsp_running_id    (rsp_running_id),
      .rsp_running_left  (rsp_running_left),
      .rsp_finished      (rsp_finished),
      .rsp_finished_id   (rsp_finished_id),
      .rsp_job_count     (rsp_job_count),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

### rtl/core/jqs_ram.sv
module jqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/jqs_ctrl.sv
module jqs_ctrl
   import jqs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  jqs_status_type status,
   output jqs_cmd_type    cmd
);

   jqs_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_busy;

   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (!status.req_func) begin
               if (status.full) state_in = ST_HEAD_RD;
               else if (status.mode) state_in = ST_SCAN_RD;
               else state_in = ST_INSERT;
            end else if (status.empty) begin
               state_in = ST_HEAD_RD;
            end else begin
               state_in = ST_TICK_RD;
            end
         end
         ST_SCAN_RD: begin
            state_in = status.cursor_at_count ? ST_INSERT : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            state_in = status.match ? ST_SHIFT_RD : ST_SCAN_RD;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            state_in = status.cursor_next_is_pos ? ST_INSERT : ST_SHIFT_RD;
         end
         ST_INSERT:  state_in = ST_HEAD_RD;
         ST_TICK_RD: state_in = ST_TICK_WR;
         ST_TICK_WR: state_in = ST_HEAD_RD;
         ST_HEAD_RD: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_HEAD;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_DECODE: begin
            cmd.cursor_clr      = status.req_func || status.mode;
            cmd.cursor_to_count = !status.req_func && !status.mode;
         end
         ST_SCAN_RD: begin
            cmd.rd_sel          = RD_CURSOR;
            cmd.pos_from_cursor = status.cursor_at_count;
         end
         ST_SCAN_CHK: begin
            cmd.rd_sel          = RD_CURSOR;
            cmd.pos_from_cursor = status.match;
            cmd.cursor_to_count = status.match;
            cmd.cursor_inc      = !status.match;
         end
         ST_SHIFT_RD: cmd.rd_sel = RD_CURSOR_M1;
         ST_SHIFT_WR: begin
            cmd.rd_sel     = RD_CURSOR_M1;
            cmd.shift_wr   = 1'b1;
            cmd.cursor_dec = 1'b1;
         end
         ST_INSERT:  cmd.insert = 1'b1;
         ST_TICK_RD: cmd.rd_sel = RD_HEAD;
         ST_TICK_WR: begin
            cmd.rd_sel      = RD_HEAD;
            cmd.tick_update = 1'b1;
         end
         ST_HEAD_RD: cmd.rd_sel = RD_HEAD;
         ST_DONE: begin
            cmd.rd_sel   = RD_HEAD;
            cmd.load_rsp = !rsp_busy;
         end
         default: cmd = '0;
      endcase
   end

   // Result valid flag: set as the result register loads, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A new result only appears after the head has been read back.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the completion state");

   // A job is never written into a full table.
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !status.full)
      else $error("insert issued on a full table");

endmodule

### rtl/core/jqs_datapath.sv
module jqs_datapath
   import jqs_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data,
   input  logic           req_func,
   input  logic [7:0]     req_job_id,
   input  logic [15:0]    req_job_duration,
   input  logic [7:0]     req_job_priority,
   output logic           rsp_accepted,
   output logic           rsp_running_valid,
   output logic [7:0]     rsp_running_id,
   output logic [15:0]    rsp_running_left,
   output logic           rsp_finished,
   output logic [7:0]     rsp_finished_id,
   output logic [4:0]     rsp_job_count,
   input  jqs_cmd_type    cmd,
   output jqs_status_type status
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = CW + 1;

   // Logical position to memory address, the table being a ring from the head.
   function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                          input logic [CW-1:0] idx);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(idx);
      if (sum >= SW'(TABLE_DEPTH)) sum = sum - SW'(TABLE_DEPTH);
      return sum[IW-1:0];
   endfunction

   logic                mode_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [CW-1:0]       cursor_ff, cursor_in;
   logic [CW-1:0]       pos_ff;
   logic                func_ff;
   jqs_entry_type       new_ff;
   logic                accepted_ff, finished_ff;
   logic [7:0]          fin_id_ff;

   logic                rsp_accepted_ff, rsp_running_valid_ff, rsp_finished_ff;
   logic [7:0]          rsp_running_id_ff, rsp_finished_id_ff;
   logic [15:0]         rsp_running_left_ff;
   logic [4:0]          rsp_job_count_ff;

   logic [CW-1:0]       rd_idx;
   logic [IW-1:0]       rd_addr, wr_addr;
   logic                wr_en;
   jqs_entry_type       wr_data, rd_data;
   logic [15:0]         tick_left;
   logic                tick_done;

   // Job memory.
   jqs_ram #(
      .WIDTH ($bits(jqs_entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read address selection.
   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD:      rd_idx = '0;
         RD_CURSOR:    rd_idx = cursor_ff;
         RD_CURSOR_M1: rd_idx = cursor_ff - 1'b1;
         default:      rd_idx = '0;
      endcase
   end
   assign rd_addr = phys(head_ff, rd_idx);

   // Tick arithmetic on the head entry.
   assign tick_left = (rd_data.left != 16'd0) ? rd_data.left - 16'd1 : 16'd0;
   assign tick_done = (tick_left == 16'd0);

   // Write port: shifted entry, new entry or decremented head.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = phys(head_ff, cursor_ff);
      wr_data = rd_data;
      if (cmd.shift_wr) begin
         wr_en = 1'b1;
      end else if (cmd.insert) begin
         wr_en   = 1'b1;
         wr_data = new_ff;
      end else if (cmd.tick_update) begin
         wr_en        = !tick_done;
         wr_addr      = head_ff;
         wr_data.left = tick_left;
      end
   end

   // Fill count, head pointer and scan cursor.
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      cursor_in = cursor_ff;
      if (cmd.insert) count_in = count_ff + 1'b1;
      if (cmd.tick_update && tick_done) begin
         count_in = count_ff - 1'b1;
         head_in  = (head_ff == IW'(TABLE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (cmd.cursor_clr) cursor_in = '0;
      else if (cmd.cursor_to_count) cursor_in = count_ff;
      else if (cmd.cursor_inc) cursor_in = cursor_ff + 1'b1;
      else if (cmd.cursor_dec) cursor_in = cursor_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (cmd.pos_from_cursor) pos_ff <= cursor_ff;
      if (cmd.load_req) begin
         func_ff               <= req_func;
         new_ff.id             <= req_job_id;
         new_ff.priority_level <= req_job_priority;
         new_ff.left           <= (req_job_duration == 16'd0) ? 16'd1 : req_job_duration;
         accepted_ff           <= 1'b0;
         finished_ff           <= 1'b0;
         fin_id_ff             <= 8'd0;
      end
      if (cmd.insert) accepted_ff <= 1'b1;
      if (cmd.tick_update && tick_done) begin
         finished_ff <= 1'b1;
         fin_id_ff   <= rd_data.id;
      end
   end

   // Result register, loaded while the head entry sits on the read port.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_accepted_ff      <= accepted_ff;
         rsp_running_valid_ff <= (count_ff != '0);
         rsp_running_id_ff    <= (count_ff != '0) ? rd_data.id : 8'd0;
         rsp_running_left_ff  <= (count_ff != '0) ? rd_data.left : 16'd0;
         rsp_finished_ff      <= finished_ff;
         rsp_finished_id_ff   <= fin_id_ff;
         rsp_job_count_ff     <= 5'(count_ff);
      end
   end

   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_running_valid = rsp_running_valid_ff;
   assign rsp_running_id    = rsp_running_id_ff;
   assign rsp_running_left  = rsp_running_left_ff;
   assign rsp_finished      = rsp_finished_ff;
   assign rsp_finished_id   = rsp_finished_id_ff;
   assign rsp_job_count     = rsp_job_count_ff;

   // Status to the controller.
   always_comb begin
      status.req_func           = func_ff;
      status.full               = (count_ff == CW'(TABLE_DEPTH));
      status.empty              = (count_ff == '0);
      status.mode               = mode_ff;
      status.cursor_at_count    = (cursor_ff == count_ff);
      status.match              = (rd_data.priority_level > new_ff.priority_level) ||
                                  ((rd_data.priority_level == new_ff.priority_level) &&
                                   (rd_data.left > new_ff.left));
      status.cursor_next_is_pos = (cursor_ff == pos_ff + 1'b1);
   end

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("job count above table depth");

   // Every insert grows the table by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the table");

endmodule
